[rtl/adaptive_paced_tx_queue_top_defines.svh]
// ----------------------------------------------------------------------------
// adaptive paced transmit queue - assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_PACED_TX_QUEUE_TOP_DEFINES_SVH
`define ADAPTIVE_PACED_TX_QUEUE_TOP_DEFINES_SVH

// property checked at every rising edge outside reset
`define APTQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define APTQ_NEVER(lbl, cond, msg) \
    `APTQ_ASSERT(lbl, !(cond), msg)

`endif

[rtl/aptq_pkg.sv]
// ----------------------------------------------------------------------------
// aptq_pkg
// types, codes and constants of the adaptive paced transmit queue
// ----------------------------------------------------------------------------
package aptq_pkg;

    localparam int APTQ_QUEUE_DEPTH = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SVC_W      = 21;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGAIN_DELAY  = 2'd2;

    // reset values of the registers
    localparam logic [6:0]  QUEUE_LIMIT_RST  = 7'd64;
    localparam logic [15:0] HOLDOFF_RST      = 16'd100;
    localparam logic [15:0] REGAIN_DELAY_RST = 16'd200;

    // item kinds
    localparam logic [1:0] OP_ARRIVAL  = 2'd0;
    localparam logic [1:0] OP_FEEDBACK = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    // result kinds
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_SENT = 2'd1;
    localparam logic [1:0] EV_DROP = 2'd2;

    localparam logic [7:0] SLOW_MAX = 8'd255;

    // floor(x / 10) = (x * RECIP_10) >> RECIP_SHIFT, exact for x below 2^26
    localparam logic [23:0] RECIP_10    = 24'hCCCCCD;
    localparam int          RECIP_SHIFT = 27;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] pkt_tag;
        logic [15:0] duration;
        logic        queue_full_flag;
        logic        receiver_full_flag;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       event_res;
        logic [15:0]      out_tag;
        logic [SVC_W-1:0] service_ticks;
        logic [7:0]       slowdown;
        logic [6:0]       queue_length;
    } out_item_t;

    // one result on its way through the service-time pipeline
    typedef struct packed {
        logic [1:0]  ev;
        logic [15:0] tag;
        logic [15:0] dur;
        logic [7:0]  slow;
        logic [6:0]  qlen;
    } svc_req_t;

    // status back from the service-time pipeline
    typedef struct packed {
        logic             load;
        logic [SVC_W-1:0] ticks;
        logic             start_pending;
    } svc_stat_t;

endpackage

[rtl/aptq_stream.sv]
// ----------------------------------------------------------------------------
// aptq_stream
// valid/ready channel carrying one payload of type T per transaction
// ----------------------------------------------------------------------------
interface aptq_stream #(parameter type T = logic);

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

[rtl/aptq_ram.sv]
// ----------------------------------------------------------------------------
// aptq_ram
// generic single-write, single-read synchronous ram with registered read
// ----------------------------------------------------------------------------
module aptq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds while no read is issued
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/aptq_svc.sv]
// ----------------------------------------------------------------------------
// aptq_svc
// service-time pipeline: duration * slowdown, divide by ten, add and floor
// ----------------------------------------------------------------------------
module aptq_svc import aptq_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      req_valid,
    input  svc_req_t  req,
    output logic      res_valid,
    output out_item_t res,
    output svc_stat_t stat
);

    logic             sa_valid_reg;
    logic             sa_valid_next;
    svc_req_t         sa_reg;
    logic [23:0]      sa_prod_reg;
    logic [23:0]      sa_prod_next;

    logic             ob_valid_reg;
    logic             ob_valid_next;
    out_item_t        ob_reg;
    out_item_t        ob_next;

    logic [47:0]      quot_full;
    logic [SVC_W-1:0] quot;
    logic [SVC_W-1:0] ticks_sum;
    logic [SVC_W-1:0] ticks;

    // stage a: product of duration and slowdown
    assign sa_valid_next = req_valid;
    assign sa_prod_next  = 24'(req.dur) * 24'(req.slow);

    // stage b: reciprocal multiply for the tenths, add the duration, then floor to one
    always_comb
    begin
        quot_full = 48'(sa_prod_reg) * 48'(RECIP_10);
        quot      = SVC_W'(quot_full >> RECIP_SHIFT);
        ticks_sum = SVC_W'(sa_reg.dur) + quot;
        ticks     = (ticks_sum == '0) ? SVC_W'(1) : ticks_sum;
    end

    always_comb
    begin
        ob_valid_next           = sa_valid_reg;
        ob_next.event_res       = sa_reg.ev;
        ob_next.out_tag         = sa_reg.tag;
        ob_next.service_ticks   = (sa_reg.ev == EV_SENT) ? ticks : '0;
        ob_next.slowdown        = sa_reg.slow;
        ob_next.queue_length    = sa_reg.qlen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg <= 1'b0;
            ob_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sa_valid_reg <= sa_valid_next;
            ob_valid_reg <= ob_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_reg      <= req;
            sa_prod_reg <= sa_prod_next;
            ob_reg      <= ob_next;
        end
    end

    assign res_valid          = ob_valid_reg;
    assign res                = ob_reg;
    assign stat.start_pending = sa_valid_reg && (sa_reg.ev == EV_SENT);
    assign stat.load          = adv && stat.start_pending;
    assign stat.ticks         = ticks;

endmodule

[rtl/adaptive_paced_tx_queue_top.sv]
// ----------------------------------------------------------------------------
// adaptive_paced_tx_queue_top
// transmit pacer with a bounded packet fifo held in a synchronous ram
// ----------------------------------------------------------------------------
//  channel   direction  payload      notes
//  in_ch     sink       in_item_t    arrival, feedback or tick, one per transaction
//  out_ch    source     out_item_t   exactly one result per input transaction
//  cfg_*     write      16-bit data  queue limit, holdoff, regain delay
//
//  one input transaction per cycle while no tick is held off and the output is not stalled;
//  a result passes the decode, stage a and output registers; a tick is held off after a
//  packet start, until the two-stage service-time multiply has written the busy count back
//  reset clears all control state at once; fifo ram contents are not cleared,
//  only entries already written are read
//  a stalled output freezes the whole pipeline, ram read data included
// ----------------------------------------------------------------------------
`include "adaptive_paced_tx_queue_top_defines.svh"

module adaptive_paced_tx_queue_top import aptq_pkg::*; #(
    parameter int QUEUE_DEPTH = APTQ_QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    aptq_stream.sink              in_ch,
    aptq_stream.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = (CW > 7) ? CW : 7;
    localparam int SW = CW + 1;

    // configuration registers
    logic [6:0]       qlimit_reg;
    logic [15:0]      holdoff_reg;
    logic [15:0]      regain_reg;

    // pacer state
    logic [CW-1:0]    count_reg,  count_next;
    logic [AW-1:0]    head_reg,   head_next;
    logic             busy_reg,   busy_next;
    logic [SVC_W-1:0] rem_reg,    rem_next;
    logic [7:0]       slow_reg,   slow_next;
    logic [31:0]      now_reg,    now_next;
    logic [31:0]      last_reg,   last_next;

    // decode stage towards the service-time pipeline
    logic             p1_valid_reg;
    svc_req_t         p1_reg,     p1_next;
    logic             p1_mem_reg, p1_mem_next;

    in_item_t         item;
    logic             in_acc;
    logic             adv;
    logic             pend;
    logic             hazard;

    logic [31:0]      elapsed;
    logic [7:0]       slow_rg;
    logic [SVC_W-1:0] rem_dec;
    logic [LW-1:0]    lim_ext;
    logic [LW-1:0]    cnt_ext;
    logic [LW-1:0]    depth_ext;
    logic [AW-1:0]    head_inc;
    logic [SW-1:0]    tail_sum;
    logic [AW-1:0]    waddr;

    logic             ram_we;
    logic             ram_re;
    logic [31:0]      ram_rdata;

    svc_req_t         req;
    svc_stat_t        svc_stat;
    logic             res_valid;
    out_item_t        res;

    assign item = in_ch.data;

    // whole pipeline moves when the output register is free or being taken
    assign adv    = !res_valid || out_ch.ready;
    // a start whose busy count is not yet written back blocks ticks only
    assign pend   = (p1_valid_reg && (p1_reg.ev == EV_SENT)) || svc_stat.start_pending;
    assign hazard = (item.op == OP_TICK) && pend;
    assign in_ch.ready = adv && !hazard;
    assign in_acc      = in_ch.valid && in_ch.ready;

    // limit above the depth acts as the depth
    assign depth_ext = LW'(QUEUE_DEPTH);
    assign lim_ext   = (LW'(qlimit_reg) > depth_ext) ? depth_ext : LW'(qlimit_reg);
    assign cnt_ext   = LW'(count_reg);

    // fifo pointers, wrapping at any depth
    assign head_inc = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign waddr    = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                     : AW'(tail_sum);

    // per-item decision on the current state
    always_comb
    begin
        now_next    = (item.op == OP_TICK) ? now_reg + 32'd1 : now_reg;
        elapsed     = now_next - last_reg;
        // regain step runs on every item
        slow_rg     = ((elapsed >= 32'(regain_reg)) && (slow_reg > 8'd1)) ? slow_reg - 8'd1
                                                                          : slow_reg;
        rem_dec     = (rem_reg != '0) ? rem_reg - SVC_W'(1) : '0;

        count_next  = count_reg;
        head_next   = head_reg;
        busy_next   = busy_reg;
        rem_next    = rem_reg;
        slow_next   = slow_rg;
        last_next   = last_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        p1_mem_next = 1'b0;
        p1_next.ev  = EV_NONE;
        p1_next.tag = '0;
        p1_next.dur = '0;

        unique case (item.op)
            OP_ARRIVAL:
            begin
                if (cnt_ext >= lim_ext)
                begin
                    p1_next.ev  = EV_DROP;
                    p1_next.tag = item.pkt_tag;
                end
                else if (busy_reg)
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    // idle server means an empty fifo: the packet goes straight out
                    p1_next.ev  = EV_SENT;
                    p1_next.tag = item.pkt_tag;
                    p1_next.dur = item.duration;
                    busy_next   = 1'b1;
                    head_next   = head_inc;
                end
            end
            OP_FEEDBACK:
            begin
                if ((item.queue_full_flag || item.receiver_full_flag)
                    && (elapsed >= 32'(holdoff_reg)))
                begin
                    slow_next = (slow_rg < SLOW_MAX) ? slow_rg + 8'd1 : slow_rg;
                    last_next = now_next;
                end
            end
            OP_TICK:
            begin
                if (busy_reg)
                begin
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        if (count_reg != '0)
                        begin
                            // head entry comes out of the ram next cycle
                            ram_re      = 1'b1;
                            p1_mem_next = 1'b1;
                            p1_next.ev  = EV_SENT;
                            head_next   = head_inc;
                            count_next  = count_reg - CW'(1);
                        end
                        else
                        begin
                            busy_next = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                // unused code: regain step only
            end
        endcase

        p1_next.slow = slow_next;
        p1_next.qlen = 7'(count_next);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlimit_reg  <= QUEUE_LIMIT_RST;
            holdoff_reg <= HOLDOFF_RST;
            regain_reg  <= REGAIN_DELAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_QUEUE_LIMIT:  qlimit_reg  <= cfg_wdata[6:0];
                CFG_HOLDOFF:      holdoff_reg <= cfg_wdata;
                CFG_REGAIN_DELAY: regain_reg  <= cfg_wdata;
                default:
                begin
                    // index beyond the list is ignored
                end
            endcase
        end
    end

    // pacer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg  <= '0;
            busy_reg  <= 1'b0;
            rem_reg   <= '0;
            slow_reg  <= '0;
            now_reg   <= '0;
            last_reg  <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                count_reg <= count_next;
                head_reg  <= head_next;
                busy_reg  <= busy_next;
                slow_reg  <= slow_next;
                now_reg   <= now_next;
                last_reg  <= last_next;
            end
            // write-back of the scaled busy time wins; ticks are held off meanwhile
            if (svc_stat.load)
            begin
                rem_reg <= svc_stat.ticks;
            end
            else if (in_acc)
            begin
                rem_reg <= rem_next;
            end
        end
    end

    // decode stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= in_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg     <= p1_next;
            p1_mem_reg <= p1_mem_next;
        end
    end

    aptq_ram #(
        .WIDTH (32),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (ram_we && in_acc),
        .waddr (waddr),
        .wdata ({item.duration, item.pkt_tag}),
        .re    (ram_re && in_acc),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // popped entries take tag and duration from the ram
    always_comb
    begin
        req     = p1_reg;
        if (p1_mem_reg)
        begin
            req.tag = ram_rdata[15:0];
            req.dur = ram_rdata[31:16];
        end
    end

    aptq_svc u_svc (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .req_valid (p1_valid_reg),
        .req       (req),
        .res_valid (res_valid),
        .res       (res),
        .stat      (svc_stat)
    );

    assign out_ch.valid = res_valid;
    assign out_ch.data  = res;

    `APTQ_NEVER(a_tick_on_pending, in_acc && (item.op == OP_TICK) && pend, "early tick")
    `APTQ_NEVER(a_idle_nonempty, !busy_reg && (count_reg != '0), "idle with packets queued")
    `APTQ_NEVER(a_count_bound, cnt_ext > depth_ext, "fifo count above depth")
    `APTQ_ASSERT(a_rem_loaded, (busy_reg && !pend) |-> (rem_reg != '0), "no ticks left")
    `APTQ_ASSERT(a_load_busy, svc_stat.load |-> busy_reg, "busy time written back while idle")

endmodule

[tb/adaptive_paced_tx_queue_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_paced_tx_queue_top_tb
// self-checking bench for the adaptive paced transmit queue: a directed table
// of arrivals, feedback, ticks and register writes, then random phases under
// several register settings; every result is checked against its typed table row or
// a cycle-free model of the pacer, with random idling on both channels
// ----------------------------------------------------------------------------
module adaptive_paced_tx_queue_top_tb;
    import aptq_pkg::*;

    localparam int QDEPTH        = APTQ_QUEUE_DEPTH;
    localparam int WATCHDOG_MAX  = 3000;   // idle cycles with no transaction at all
    localparam int LONG_HOLD     = 300;    // receiver hold-off to back the block up
    localparam int CFG_SETTLE    = 6;      // pause after the last result before a write
    localparam int END_SETTLE    = 20;

    // codes the package leaves unnamed
    localparam logic [1:0]           OP_UNUSED      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    // one row of the directed table: a register write or an input transaction
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [15:0]          cfg_val;
        in_item_t             item;
        bit                   typed;
        out_item_t            want;
    } plan_row_t;

    // one random phase: register setting and mix of item kinds (percent)
    typedef struct {
        logic [6:0]  limit;
        logic [15:0] holdoff;
        logic [15:0] regain;
        int          count;
        int          pct_arr;
        int          pct_fb;
        int          pct_tick;
        int          dur_max;
        bit          wide_dur;
        bit          rnd_cfg;
    } phase_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    aptq_stream #(.T(in_item_t))  in_if ();
    aptq_stream #(.T(out_item_t)) out_if ();

    adaptive_paced_tx_queue_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_if),
        .out_ch    (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // pacer model: its own copy of the fifo, server, slowdown and clock
    // ------------------------------------------------------------------------
    logic [31:0] pkt_store [QDEPTH];       // duration in 31..16, tag in 15..0
    int unsigned queued      = 0;
    int unsigned head_slot   = 0;
    int unsigned busy_left   = 0;
    bit          serving     = 1'b0;
    logic [7:0]  slow_now    = '0;
    logic [31:0] tick_now    = '0;
    logic [31:0] last_raise  = '0;
    logic [6:0]  limit_reg   = QUEUE_LIMIT_RST;
    logic [15:0] holdoff_reg = HOLDOFF_RST;
    logic [15:0] regain_reg  = REGAIN_DELAY_RST;

    out_item_t   expected_results [$];     // results still owed by the block, oldest first
    int          mismatch_count   = 0;
    bit          hold_output_req  = 1'b0;  // asks the receiver for one long hold-off
    out_item_t   want_now;
    int          idle_cycles      = 0;

    // pop the head packet and start serving it, scaled by the slowdown
    function automatic void serve_head(inout out_item_t r);
        logic [31:0] entry;
        int unsigned dur_v;
        int unsigned svc;
        entry     = pkt_store[head_slot];
        head_slot = (head_slot + 1) % QDEPTH;
        queued    = queued - 1;
        dur_v     = entry[31:16];
        svc       = dur_v + (dur_v * slow_now) / 10;
        if (svc == 0)
            svc = 1;                       // zero duration still costs a tick
        busy_left       = svc;
        serving         = 1'b1;
        r.event_res     = EV_SENT;
        r.out_tag       = entry[15:0];
        r.service_ticks = svc[SVC_W-1:0];
    endfunction

    function automatic out_item_t predict_pacer(in_item_t it);
        out_item_t   r;
        logic [31:0] elapsed;
        int unsigned lim;
        r = '0;
        if (it.op == OP_TICK)
            tick_now = tick_now + 32'd1;
        // regain runs on every transaction, before its own action
        elapsed = tick_now - last_raise;
        if (elapsed >= 32'(regain_reg) && slow_now > 8'd1)
            slow_now = slow_now - 8'd1;
        case (it.op)
            OP_ARRIVAL:
            begin
                lim = (limit_reg > QDEPTH) ? QDEPTH : limit_reg;
                if (queued >= lim)
                begin
                    r.event_res = EV_DROP;
                    r.out_tag   = it.pkt_tag;
                end
                else
                begin
                    pkt_store[(head_slot + queued) % QDEPTH] = {it.duration, it.pkt_tag};
                    queued = queued + 1;
                    if (!serving)
                        serve_head(r);
                end
            end
            OP_FEEDBACK:
            begin
                if ((it.queue_full_flag || it.receiver_full_flag) &&
                    elapsed >= 32'(holdoff_reg))
                begin
                    if (slow_now < SLOW_MAX)
                        slow_now = slow_now + 8'd1;
                    last_raise = tick_now;
                end
            end
            OP_TICK:
            begin
                if (serving)
                begin
                    if (busy_left > 0)
                        busy_left = busy_left - 1;
                    if (busy_left == 0)
                    begin
                        if (queued > 0)
                            serve_head(r);
                        else
                            serving = 1'b0;
                    end
                end
            end
            default: ;                     // unused code: regain only
        endcase
        r.slowdown     = slow_now;
        r.queue_length = queued[6:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // directed table helpers
    // ------------------------------------------------------------------------
    function automatic plan_row_t item_row(logic [1:0] op, logic [15:0] tag,
                                           logic [15:0] dur, logic qf, logic rf);
        plan_row_t r;
        r         = '{default: '0};
        r.item    = '{op, tag, dur, qf, rf};
        return r;
    endfunction

    function automatic plan_row_t item_row_chk(logic [1:0] op, logic [15:0] tag,
                                               logic [15:0] dur, logic qf, logic rf,
                                               logic [1:0] ev, logic [15:0] otag,
                                               logic [SVC_W-1:0] svc, logic [7:0] slow,
                                               logic [6:0] qlen);
        plan_row_t r;
        r       = item_row(op, tag, dur, qf, rf);
        r.typed = 1'b1;
        r.want  = '{ev, otag, svc, slow, qlen};
        return r;
    endfunction

    function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        plan_row_t r;
        r         = '{default: '0};
        r.is_cfg  = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    // idle gap: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic in_item_t draw_item(phase_t ph);
        in_item_t it;
        int       r;
        r                     = $urandom_range(0, 99);
        it.pkt_tag            = 16'($urandom);
        it.queue_full_flag    = 1'($urandom);
        it.receiver_full_flag = 1'($urandom);
        if (r < ph.pct_arr)
            it.op = OP_ARRIVAL;
        else if (r < ph.pct_arr + ph.pct_fb)
            it.op = OP_FEEDBACK;
        else if (r < ph.pct_arr + ph.pct_fb + ph.pct_tick)
            it.op = OP_TICK;
        else
            it.op = OP_UNUSED;
        // short packets keep the server turning over; a few long ones
        if (ph.wide_dur && $urandom_range(0, 49) == 0)
            it.duration = 16'($urandom);
        else if ($urandom_range(0, 9) == 0)
            it.duration = 16'($urandom_range(0, 63));
        else
            it.duration = 16'($urandom_range(0, ph.dur_max));
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------
    // offer one transaction and hold it until taken, then log what is owed
    task automatic send_item(input in_item_t it, input int gap, input bit typed,
                             input out_item_t want);
        out_item_t predicted;
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        predicted = predict_pacer(it);
        // typed rows carry their own expectation, the model still advances
        expected_results.push_back(typed ? want : predicted);
    endtask

    // stop offering and wait for every owed result, then let the pipe empty
    task automatic settle_block();
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_QUEUE_LIMIT:  limit_reg   = val[6:0];
            CFG_HOLDOFF:      holdoff_reg = val;
            CFG_REGAIN_DELAY: regain_reg  = val;
            default: ;                     // index out of range has no effect
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // receiver side: random ready, long clear runs, one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        int run;
        int gap;
        out_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_output_req)
            begin
                hold_output_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                run = ($urandom_range(0, 99) < 20) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 8);
                out_if.ready <= 1'b1;
                repeat (run) @(posedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    out_if.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker: each accepted result against the oldest owed one
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing owed: ev %0d tag %h svc %0d",
                             $realtime, out_if.data.event_res, out_if.data.out_tag,
                             out_if.data.service_ticks);
            end
            else
            begin
                want_now = expected_results.pop_front();
                if (out_if.data !== want_now)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $write("%0t: mismatch ev %0d/%0d tag %h/%h svc %0d/%0d",
                               $realtime,
                               want_now.event_res, out_if.data.event_res,
                               want_now.out_tag, out_if.data.out_tag,
                               want_now.service_ticks, out_if.data.service_ticks);
                        $display(" slow %0d/%0d qlen %0d/%0d (expected/actual)",
                                 want_now.slowdown, out_if.data.slowdown,
                                 want_now.queue_length, out_if.data.queue_length);
                    end
                end
            end
        end
    end

    // watchdog: too long with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    plan_row_t directed_plan [21];
    phase_t    phase_plan [6];

    initial
    begin
        phase_t   ph;
        bit       steady;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;

        directed_plan = '{
            // empty server: sent at once, zero duration floored to one tick
            item_row_chk(OP_ARRIVAL, 16'h0000, 16'd0, 1'b0, 1'b0,
                         EV_SENT, 16'h0000, 21'd1, 8'd0, 7'd0),
            item_row_chk(OP_ARRIVAL, 16'hFFFF, 16'd3, 1'b0, 1'b0,
                         EV_NONE, 16'h0000, 21'd0, 8'd0, 7'd1),
            // busy count runs out, queued packet goes
            item_row_chk(OP_TICK, 16'h0000, 16'd0, 1'b0, 1'b0,
                         EV_SENT, 16'hFFFF, 21'd3, 8'd0, 7'd0),
            // feedback inside the holdoff does nothing
            item_row_chk(OP_FEEDBACK, 16'h0000, 16'd0, 1'b1, 1'b1,
                         EV_NONE, 16'h0000, 21'd0, 8'd0, 7'd0),
            // unused item code, every bit set
            item_row_chk(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1,
                         EV_NONE, 16'h0000, 21'd0, 8'd0, 7'd0),
            // feedback with no flags
            item_row_chk(OP_FEEDBACK, 16'h0000, 16'd0, 1'b0, 1'b0,
                         EV_NONE, 16'h0000, 21'd0, 8'd0, 7'd0),
            // zero holdoff: every flagged feedback raises
            cfg_row(CFG_HOLDOFF, 16'd0),
            item_row_chk(OP_FEEDBACK, 16'h0000, 16'd0, 1'b1, 1'b0,
                         EV_NONE, 16'h0000, 21'd0, 8'd1, 7'd0),
            item_row_chk(OP_FEEDBACK, 16'h0000, 16'd0, 1'b0, 1'b1,
                         EV_NONE, 16'h0000, 21'd0, 8'd2, 7'd0),
            // write to an index with no register behind it
            cfg_row(CFG_IDX_UNUSED, 16'hFFFF),
            // zero limit drops everything
            cfg_row(CFG_QUEUE_LIMIT, 16'd0),
            item_row_chk(OP_ARRIVAL, 16'hABCD, 16'hFFFF, 1'b0, 1'b0,
                         EV_DROP, 16'hABCD, 21'd0, 8'd2, 7'd0),
            // limit beyond the fifo depth
            cfg_row(CFG_QUEUE_LIMIT, 16'd127),
            item_row(OP_ARRIVAL, 16'h5A5A, 16'd10, 1'b0, 1'b0),
            // zero regain delay: slowdown falls on every transaction while above one
            cfg_row(CFG_REGAIN_DELAY, 16'd0),
            item_row(OP_TICK, 16'h0000, 16'd0, 1'b0, 1'b0),
            item_row(OP_TICK, 16'h0000, 16'd0, 1'b0, 1'b0),
            item_row(OP_TICK, 16'h0000, 16'd0, 1'b0, 1'b0),
            cfg_row(CFG_REGAIN_DELAY, 16'hFFFF),
            cfg_row(CFG_HOLDOFF, 16'hFFFF),
            item_row(OP_FEEDBACK, 16'h8001, 16'h7FFE, 1'b1, 1'b1)
        };

        //              limit   holdoff   regain     cnt  arr fb tick dmax wide rnd
        phase_plan = '{
            '{7'd64,  16'd100,   16'd200,   300, 35, 15, 48, 12, 1'b0, 1'b0},
            '{7'd4,   16'd2,     16'd5,     300, 40, 25, 33, 12, 1'b0, 1'b0},
            // saturate the slowdown, overfill past the fifo depth
            '{7'd127, 16'd0,     16'hFFFF,  500, 20, 75,  3,  4, 1'b0, 1'b0},
            // drop everything while the backlog drains and slowdown falls
            '{7'd0,   16'hFFFF,  16'd0,     250, 30, 10, 58, 12, 1'b0, 1'b0},
            '{7'd64,  16'd1,     16'd1,     300, 30, 30, 38, 12, 1'b0, 1'b0},
            '{7'd64,  16'd1,     16'd1,     300, 35, 20, 43, 12, 1'b1, 1'b1}
        };

        // reset once at the start
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_cfg)
                cfg_write(directed_plan[i].cfg_idx, directed_plan[i].cfg_val);
            else
                send_item(directed_plan[i].item, pick_gap(), directed_plan[i].typed,
                          directed_plan[i].want);
        end

        // random phases, each under its own register setting
        foreach (phase_plan[p])
        begin
            ph = phase_plan[p];
            if (ph.rnd_cfg)
            begin
                ph.limit   = 7'($urandom_range(1, 127));
                ph.holdoff = 16'($urandom_range(0, 20));
                ph.regain  = 16'($urandom_range(0, 40));
            end
            cfg_write(CFG_QUEUE_LIMIT, {9'd0, ph.limit});
            cfg_write(CFG_HOLDOFF, ph.holdoff);
            cfg_write(CFG_REGAIN_DELAY, ph.regain);
            steady = 1'b0;
            for (int k = 0; k < ph.count; k++)
            begin
                // stretches with no sender gaps now and then
                if (k % 64 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                // back the block up behind a stalled receiver once
                if (p == 0 && k == 120)
                    hold_output_req = 1'b1;
                send_item(draw_item(ph), steady ? 0 : pick_gap(), 1'b0, '0);
            end
        end

        // drain and let the pipeline run dry
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (END_SETTLE) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
